// File: design/mpwm_pkg.sv
// Shared constants, register codes and types of the masked pattern window matcher.
package mpwm_pkg;

   localparam int PATTERN_MAX_DEFAULT   = 16;
   localparam int POSITION_BITS_DEFAULT = 25;

   localparam int PATTERN_BYTES = 16;
   localparam int PATTERN_BITS  = 8 * PATTERN_BYTES;
   localparam int LEN_BITS      = 5;
   localparam int OFFSET_BITS   = 24;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_MASK_LOW       = 3'd2,
      CSR_MASK_HIGH      = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4,
      CSR_START_OFFSET   = 3'd5,
      CSR_END_OFFSET     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern;
      logic [PATTERN_BITS-1:0] mask;
      logic [LEN_BITS-1:0]     pattern_length;
      logic [OFFSET_BITS-1:0]  start_offset;
      logic [OFFSET_BITS-1:0]  end_offset;
   } cfg_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
   } eval_type;

   typedef struct packed {
      logic matched;
      logic settled;
   } result_type;

endpackage

// File: design/mpwm_compare.sv
// Masked window compare and offset range checks for one incoming byte.
module mpwm_compare
   import mpwm_pkg::*;
#(
   parameter int PATTERN_MAX   = PATTERN_MAX_DEFAULT,
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  cfg_type                          cfg,
   input  logic [PATTERN_MAX-1:0][7:0]      window,
   input  logic [POSITION_BITS-1:0]         count,
   input  logic                             known,
   output eval_type                         eval
);

   localparam int IDX_BITS = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int CW = ((POSITION_BITS > OFFSET_BITS + 1) ? POSITION_BITS
                                                          : OFFSET_BITS + 1) + 1;

   logic [LEN_BITS-1:0]    len;
   logic [CW-1:0]          count_w;
   logic [CW-1:0]          len_w;
   logic [CW-1:0]          start_w;
   logic [CW-1:0]          end_w;
   logic [CW-1:0]          pos_w;
   logic [PATTERN_MAX-1:0] byte_ok;
   logic [LEN_BITS-1:0]    idx;
   logic                   in_range;

   // Clamp an over-long length to the window depth.
   assign len = (cfg.pattern_length > LEN_BITS'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX)
                                                              : cfg.pattern_length;

   assign count_w = CW'(count);
   assign len_w   = CW'(len);
   assign start_w = CW'(cfg.start_offset);
   assign end_w   = CW'(cfg.end_offset);
   assign pos_w   = count_w - len_w;

   // Byte i of the pattern lines up with the byte len-1-i beats back.
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         idx        = '0;
         byte_ok[i] = 1'b1;
         if (LEN_BITS'(i) < len) begin
            idx        = len - LEN_BITS'(i) - LEN_BITS'(1);
            byte_ok[i] = ((cfg.pattern[8*i +: 8] & cfg.mask[8*i +: 8]) ==
                          (window[idx[IDX_BITS-1:0]] & cfg.mask[8*i +: 8]));
         end
      end
   end

   assign in_range = known && (len != '0) && (count_w >= len_w) &&
                     (pos_w >= start_w) && (pos_w <= end_w);

   assign eval.hit       = in_range && (&byte_ok);
   assign eval.exhausted = (len == '0) || (end_w < start_w) || !known ||
                           (count_w >= end_w + len_w);

endmodule

// File: design/masked_pattern_window_matcher.sv
// Top level of the masked pattern window matcher: registers, state and result queue.
//
//   channel   direction  handshake                    payload
//   req_      in         req_valid / req_ready        req_data_byte[7:0], req_is_last
//   rsp_      out        rsp_valid / rsp_ready        rsp_matched, rsp_settled
//   csr_      in         csr_write_enable             csr_index[2:0], csr_write_data[63:0]
//
// One byte is accepted per cycle while req_ready is high. The masked compare, the
// offset checks and the state update all happen in the cycle a beat is accepted;
// its result is registered in the output register, or in the skid entry behind a waiting result.
// A two-entry result queue (output register plus skid entry) keeps req_ready
// high while one result waits; req_ready drops only with both entries full.
// Synchronous reset clears the registers to their defaults, the byte window,
// position and match flag, and empties the result queue.
module masked_pattern_window_matcher
   import mpwm_pkg::*;
#(
   parameter int PATTERN_MAX   = PATTERN_MAX_DEFAULT,
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_is_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_matched,
   output logic                      rsp_settled,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type                     cfg_ff;
   cfg_type                     cfg_in;
   logic [PATTERN_MAX-1:0][7:0] recent_ff;
   logic [PATTERN_MAX-1:0][7:0] recent_in;
   logic [PATTERN_MAX-1:0][7:0] shifted;
   logic [POSITION_BITS-1:0]    pos_ff;
   logic [POSITION_BITS-1:0]    pos_in;
   logic [POSITION_BITS-1:0]    count;
   logic                        match_ff;
   logic                        match_in;
   logic                        match_now;
   logic                        known;
   eval_type                    eval;
   result_type                  result;
   result_type                  out_ff;
   result_type                  out_in;
   result_type                  skid_ff;
   result_type                  skid_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic                        skid_valid_ff;
   logic                        skid_valid_in;
   logic                        push;
   logic                        pop;

   // Configuration writes; an index past the list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    cfg_in.pattern[63:0]    = csr_write_data;
            CSR_PATTERN_HIGH:   cfg_in.pattern[127:64]  = csr_write_data;
            CSR_MASK_LOW:       cfg_in.mask[63:0]       = csr_write_data;
            CSR_MASK_HIGH:      cfg_in.mask[127:64]     = csr_write_data;
            CSR_PATTERN_LENGTH: cfg_in.pattern_length   = csr_write_data[LEN_BITS-1:0];
            CSR_START_OFFSET:   cfg_in.start_offset     = csr_write_data[OFFSET_BITS-1:0];
            CSR_END_OFFSET:     cfg_in.end_offset       = csr_write_data[OFFSET_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern        <= '0;
         cfg_ff.mask           <= '1;
         cfg_ff.pattern_length <= '0;
         cfg_ff.start_offset   <= '0;
         cfg_ff.end_offset     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Shift the new byte into the window; slot 0 is the newest.
   always_comb begin
      shifted[0] = req_data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         shifted[k] = recent_ff[k-1];
      end
   end

   // Hold the position once it saturates: such bytes have no known place.
   assign known = (pos_ff != '1);
   assign count = known ? pos_ff + POSITION_BITS'(1) : pos_ff;

   mpwm_compare #(
      .PATTERN_MAX   (PATTERN_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_compare (
      .cfg    (cfg_ff),
      .window (shifted),
      .count  (count),
      .known  (known),
      .eval   (eval)
   );

   assign match_now      = match_ff || eval.hit;
   assign result.matched = match_now;
   assign result.settled = match_now || eval.exhausted || req_is_last;

   assign push = req_valid && req_ready;
   assign pop  = out_valid_ff && rsp_ready;

   // Advance file state on each accepted beat; drop it all after the last byte.
   always_comb begin
      recent_in = recent_ff;
      pos_in    = pos_ff;
      match_in  = match_ff;
      if (push) begin
         if (req_is_last) begin
            recent_in = '0;
            pos_in    = '0;
            match_in  = 1'b0;
         end else begin
            recent_in = shifted;
            pos_in    = count;
            match_in  = match_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recent_ff <= '0;
         pos_ff    <= '0;
         match_ff  <= 1'b0;
      end else begin
         recent_ff <= recent_in;
         pos_ff    <= pos_in;
         match_ff  <= match_in;
      end
   end

   // Result queue: output register in front, skid entry behind it.
   assign req_ready = !skid_valid_ff;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      priority if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_matched = out_ff.matched;
   assign rsp_settled = out_ff.settled;

endmodule

// File: design/mpwm_checker.sv
// Port-level assertions for the masked pattern window matcher, bound to the top level.
module mpwm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_data_byte,
   input logic       req_is_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_matched,
   input logic       rsp_settled
);

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched) && $stable(rsp_settled))
      else $error("stalled result beat changed");

   // A waiting input beat stays offered with its payload unchanged.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data_byte) && $stable(req_is_last))
      else $error("waiting input beat changed");

   // A match is always a final answer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> rsp_settled)
      else $error("matched result not settled");

   // An accepted beat with an empty queue shows its result on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> rsp_valid)
      else $error("result missing one cycle after accept");

   // Reset empties the result queue.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result queue not empty after reset");

endmodule

bind masked_pattern_window_matcher mpwm_checker u_mpwm_checker (.*);
